>>> rtl/tauv_pkg.sv
// tauv_pkg: shared types and constants for the atlas tile uv grid block
// item and result payloads, controller states, divider operations, command and status
// no dependencies
package tauv_pkg;

	localparam int KIND_W = 2;
	localparam int POS_W = 14;
	localparam int EXT_W = 15;
	localparam int CNT_W = 4;
	localparam int PAD_W = 8;
	localparam int ATLAS_W = 15;
	localparam int OUT_W = 18;
	localparam int DIVISOR_W = 16;
	localparam int DIV_STEP_BITS = 4;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;
	localparam logic [ATLAS_W-1:0] ATLAS_RESET = 15'd1024;

	localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DESC = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

	localparam logic CFG_ATLAS_WIDTH = 1'b0;
	localparam logic CFG_ATLAS_HEIGHT = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0] region_min_x;
		logic [POS_W-1:0] region_min_y;
		logic [EXT_W-1:0] region_width;
		logic [EXT_W-1:0] region_height;
		logic [CNT_W-1:0] tiles_x;
		logic [CNT_W-1:0] tiles_y;
		logic [PAD_W-1:0] pad_x;
		logic [PAD_W-1:0] pad_y;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0] corner_u;
		logic [OUT_W-1:0] corner_v;
		logic [OUT_W-1:0] size_u;
		logic [OUT_W-1:0] size_v;
		logic last;
		logic error;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_LAUNCH,
		S_WAIT,
		S_INIT,
		S_EMIT,
		S_ERR
	} ctrl_state_t;

	typedef enum logic [2:0] {
		OP_TILE,
		OP_BLKS,
		OP_UV,
		OP_STEP,
		OP_SIZE,
		OP_ORG
	} div_op_t;

	typedef struct packed {
		logic load_item;
		logic div_start;
		logic capture;
		div_op_t op;
		logic axis;
		logic emit_init;
		logic emit_step;
		logic emit_err;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic pre_bad;
		logic q_bad;
		logic tile_last;
	} dp_stat_t;

	function automatic div_op_t next_op(input div_op_t op);
		div_op_t r;
		case (op)
			OP_TILE: r = OP_BLKS;
			OP_BLKS: r = OP_UV;
			OP_UV: r = OP_STEP;
			OP_STEP: r = OP_SIZE;
			OP_SIZE: r = OP_ORG;
			default: r = OP_TILE;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/tauv_div.sv
// tauv_div: shared restoring divider, several quotient bits per cycle
// dividend width is a multiple of the step width; registered quotient with a done pulse
// depends on tauv_pkg
module tauv_div #(
	parameter int DIVIDEND_W = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [tauv_pkg::DIVISOR_W-1:0] divisor,
	output logic done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int ITER = DIVIDEND_W / tauv_pkg::DIV_STEP_BITS;
	localparam int ICW = $clog2(ITER + 1);
	localparam int DVW = tauv_pkg::DIVISOR_W;

	logic [DIVIDEND_W-1:0] work_q;
	logic [DIVIDEND_W-1:0] work_nx;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] rem_nx;
	logic [DVW-1:0] dsr_q;
	logic [ICW-1:0] cnt_q;
	logic run_q;
	logic done_q;

	always_comb begin
		logic [DVW:0] t;
		rem_nx = rem_q;
		work_nx = work_q;
		for (int k = 0; k < tauv_pkg::DIV_STEP_BITS; k++) begin
			t = {rem_nx, work_nx[DIVIDEND_W-1]};
			work_nx = {work_nx[DIVIDEND_W-2:0], 1'b0};
			if (t >= {1'b0, dsr_q}) begin
				t = t - {1'b0, dsr_q};
				work_nx[0] = 1'b1;
			end
			rem_nx = t[DVW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= ICW'(ITER);
			end else if (run_q) begin
				cnt_q <= cnt_q - ICW'(1);
				if (cnt_q == ICW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			work_q <= work_nx;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quotient = work_q;

endmodule

>>> rtl/tauv_dp.sv
// tauv_dp: datapath for the atlas tile uv grid block
// atlas registers, item latch, per-axis setup through the shared divider, tile emission
// depends on tauv_pkg and tauv_div
module tauv_dp #(
	parameter int MAX_SUBDIVISIONS = 8,
	parameter int UV_FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [tauv_pkg::ATLAS_W-1:0] cfg_data,
	input  tauv_pkg::item_t item,
	input  tauv_pkg::dp_cmd_t cmd,
	output tauv_pkg::dp_stat_t stat,
	output tauv_pkg::result_t result,
	output logic strobe
);

	localparam int NW = $clog2(MAX_SUBDIVISIONS + 1);
	localparam int SW = UV_FRACTION_BITS + 1;
	localparam int OW = UV_FRACTION_BITS + 15;
	localparam int CW = UV_FRACTION_BITS + 16;
	localparam int DW = UV_FRACTION_BITS + 16;
	localparam int SB = tauv_pkg::DIV_STEP_BITS;
	localparam int DWP = ((DW + SB - 1) / SB) * SB;
	localparam int DVW = tauv_pkg::DIVISOR_W;
	localparam int EW = tauv_pkg::EXT_W;
	localparam int PW = tauv_pkg::PAD_W;
	localparam int TPW = PW + NW;

	function automatic logic [NW-1:0] sat_n(input logic [tauv_pkg::CNT_W-1:0] t,
		input logic m0);
		logic [NW-1:0] r;
		if (m0) begin
			r = NW'(1);
		end else if (32'(t) > MAX_SUBDIVISIONS) begin
			r = NW'(MAX_SUBDIVISIONS);
		end else begin
			r = NW'(t);
		end
		return r;
	endfunction

	function automatic logic [tauv_pkg::OUT_W-1:0] sat_out(input logic [CW-1:0] v);
		logic [tauv_pkg::OUT_W-1:0] r;
		if (v > CW'(tauv_pkg::OUT_MAX)) begin
			r = tauv_pkg::OUT_MAX;
		end else begin
			r = v[tauv_pkg::OUT_W-1:0];
		end
		return r;
	endfunction

	logic [tauv_pkg::ATLAS_W-1:0] atlas_w_q;
	logic [tauv_pkg::ATLAS_W-1:0] atlas_h_q;
	tauv_pkg::item_t item_q;

	logic [EW-1:0] tile_q;
	logic [DVW-1:0] blk_q;
	logic [EW-1:0] d_q;
	logic [SW-1:0] uv_q;
	logic [SW-1:0] step_x_q;
	logic [SW-1:0] step_y_q;
	logic [SW-1:0] size_x_q;
	logic [SW-1:0] size_y_q;
	logic [OW-1:0] org_x_q;
	logic [OW-1:0] org_y_q;

	logic [CW-1:0] cu_q;
	logic [CW-1:0] cv_q;
	logic [CW-1:0] cv0_q;
	logic [NW-1:0] ix_q;
	logic [NW-1:0] iy_q;
	tauv_pkg::result_t result_q;
	logic strobe_q;

	logic mode0;
	logic desc;
	logic [NW-1:0] nx_eff;
	logic [NW-1:0] ny_eff;
	logic [NW-1:0] nx_m1;
	logic [NW-1:0] ny_m1;
	logic [NW-1:0] n_cur;
	logic [NW-1:0] nm1_cur;
	logic [tauv_pkg::ATLAS_W-1:0] a_cur;
	logic [EW-1:0] ext_cur;
	logic [tauv_pkg::POS_W-1:0] min_cur;
	logic [PW-1:0] pad_eff;
	logic [SW-1:0] step_cur;
	logic [TPW-1:0] totpad;
	logic [DVW-1:0] ext_left;
	logic [30:0] prod_db;
	logic [SW+14:0] prod_st;
	logic [SW+13:0] prod_sm;
	logic [DWP-1:0] div_a;
	logic [DVW-1:0] div_b;
	logic div_done;
	logic [DWP-1:0] q;
	logic tile_last;

	assign mode0 = (item_q.kind == tauv_pkg::KIND_SINGLE);
	assign desc = (item_q.kind == tauv_pkg::KIND_DESC);
	assign nx_eff = sat_n(item_q.tiles_x, mode0);
	assign ny_eff = sat_n(item_q.tiles_y, mode0);
	assign nx_m1 = nx_eff - NW'(1);
	assign ny_m1 = ny_eff - NW'(1);

	assign n_cur = cmd.axis ? ny_eff : nx_eff;
	assign nm1_cur = n_cur - NW'(1);
	assign a_cur = cmd.axis ? atlas_h_q : atlas_w_q;
	assign ext_cur = cmd.axis ? item_q.region_height : item_q.region_width;
	assign min_cur = cmd.axis ? item_q.region_min_y : item_q.region_min_x;
	assign pad_eff = mode0 ? '0 : (cmd.axis ? item_q.pad_y : item_q.pad_x);
	assign step_cur = cmd.axis ? step_y_q : step_x_q;

	assign totpad = TPW'(pad_eff) * TPW'(nm1_cur);
	assign ext_left = DVW'(ext_cur) - DVW'(totpad);
	assign prod_db = 31'(d_q) * 31'(blk_q);
	assign prod_st = (SW+15)'(step_cur) * (SW+15)'(tile_q);
	assign prod_sm = (SW+14)'(step_cur) * (SW+14)'(min_cur);

	always_comb begin
		case (cmd.op)
			tauv_pkg::OP_TILE: begin
				div_a = DWP'(ext_left);
				div_b = DVW'(n_cur);
			end
			tauv_pkg::OP_BLKS: begin
				div_a = DWP'(a_cur);
				div_b = blk_q;
			end
			tauv_pkg::OP_UV: begin
				div_a = DWP'({prod_db[EW-1:0], {UV_FRACTION_BITS{1'b0}}});
				div_b = DVW'(a_cur);
			end
			tauv_pkg::OP_STEP: begin
				div_a = DWP'(uv_q);
				div_b = DVW'(d_q);
			end
			tauv_pkg::OP_SIZE: begin
				div_a = DWP'(prod_st);
				div_b = blk_q;
			end
			tauv_pkg::OP_ORG: begin
				div_a = DWP'(prod_sm);
				div_b = mode0 ? DVW'(1) : blk_q;
			end
			default: begin
				div_a = '0;
				div_b = DVW'(1);
			end
		endcase
	end

	tauv_div #(
		.DIVIDEND_W(DWP)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(div_a),
		.divisor(div_b),
		.done(div_done),
		.quotient(q)
	);

	assign tile_last = (ix_q == nx_m1) && (iy_q == ny_m1);

	always_comb begin
		stat.div_done = div_done;
		stat.tile_last = tile_last;
		stat.pre_bad = (item_q.kind == tauv_pkg::KIND_BAD) || (n_cur == '0) ||
			(DVW'(ext_cur) < DVW'(totpad));
		case (cmd.op)
			tauv_pkg::OP_TILE: stat.q_bad = (q == '0) ||
				(DVW'(a_cur) < DVW'(q[EW-1:0]) + DVW'(pad_eff));
			tauv_pkg::OP_STEP: stat.q_bad = (q == '0);
			tauv_pkg::OP_SIZE: stat.q_bad = (q == '0);
			default: stat.q_bad = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_q <= tauv_pkg::ATLAS_RESET;
			atlas_h_q <= tauv_pkg::ATLAS_RESET;
			ix_q <= '0;
			iy_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tauv_pkg::CFG_ATLAS_WIDTH: atlas_w_q <= cfg_data;
					tauv_pkg::CFG_ATLAS_HEIGHT: atlas_h_q <= cfg_data;
					default: ;
				endcase
			end
			strobe_q <= cmd.emit_step || cmd.emit_err;
			if (cmd.emit_init) begin
				ix_q <= '0;
				iy_q <= '0;
			end else if (cmd.emit_step) begin
				if (iy_q == ny_m1) begin
					iy_q <= '0;
					ix_q <= ix_q + NW'(1);
				end else begin
					iy_q <= iy_q + NW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
		if (div_done && cmd.capture) begin
			case (cmd.op)
				tauv_pkg::OP_TILE: begin
					tile_q <= q[EW-1:0];
					blk_q <= DVW'(q[EW-1:0]) + DVW'(pad_eff);
				end
				tauv_pkg::OP_BLKS: d_q <= q[EW-1:0];
				tauv_pkg::OP_UV: uv_q <= q[SW-1:0];
				tauv_pkg::OP_STEP: begin
					if (cmd.axis) begin
						step_y_q <= q[SW-1:0];
					end else begin
						step_x_q <= q[SW-1:0];
					end
				end
				tauv_pkg::OP_SIZE: begin
					if (cmd.axis) begin
						size_y_q <= q[SW-1:0];
					end else begin
						size_x_q <= q[SW-1:0];
					end
				end
				tauv_pkg::OP_ORG: begin
					if (cmd.axis) begin
						org_y_q <= q[OW-1:0];
					end else begin
						org_x_q <= q[OW-1:0];
					end
				end
				default: ;
			endcase
		end
		if (cmd.emit_init) begin
			cu_q <= CW'(org_x_q) + (desc ? CW'(nx_m1) * CW'(step_x_q) : '0);
			cv_q <= CW'(org_y_q) + (desc ? CW'(ny_m1) * CW'(step_y_q) : '0);
			cv0_q <= CW'(org_y_q) + (desc ? CW'(ny_m1) * CW'(step_y_q) : '0);
		end else if (cmd.emit_step) begin
			if (iy_q == ny_m1) begin
				cu_q <= desc ? cu_q - CW'(step_x_q) : cu_q + CW'(step_x_q);
				cv_q <= cv0_q;
			end else begin
				cv_q <= desc ? cv_q - CW'(step_y_q) : cv_q + CW'(step_y_q);
			end
		end
		if (cmd.emit_step) begin
			result_q.corner_u <= sat_out(cu_q);
			result_q.corner_v <= sat_out(cv_q);
			result_q.size_u <= sat_out(CW'(size_x_q));
			result_q.size_v <= sat_out(CW'(size_y_q));
			result_q.last <= tile_last;
			result_q.error <= 1'b0;
		end else if (cmd.emit_err) begin
			result_q.corner_u <= '0;
			result_q.corner_v <= '0;
			result_q.size_u <= '0;
			result_q.size_v <= '0;
			result_q.last <= 1'b1;
			result_q.error <= 1'b1;
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

>>> rtl/tauv_ctrl.sv
// tauv_ctrl: sequencer for the atlas tile uv grid block
// steps both axes through the divider operations, then drives tile emission or an error result
// depends on tauv_pkg
module tauv_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output tauv_pkg::dp_cmd_t cmd,
	input  tauv_pkg::dp_stat_t stat
);

	tauv_pkg::ctrl_state_t state_q;
	tauv_pkg::ctrl_state_t state_n;
	tauv_pkg::div_op_t op_q;
	tauv_pkg::div_op_t op_n;
	logic axis_q;
	logic axis_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tauv_pkg::S_IDLE;
			op_q <= tauv_pkg::OP_TILE;
			axis_q <= 1'b0;
		end else begin
			state_q <= state_n;
			op_q <= op_n;
			axis_q <= axis_n;
		end
	end

	always_comb begin
		state_n = state_q;
		op_n = op_q;
		axis_n = axis_q;
		cmd = '0;
		cmd.op = op_q;
		cmd.axis = axis_q;
		case (state_q)
			tauv_pkg::S_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					axis_n = 1'b0;
					state_n = tauv_pkg::S_CHECK;
				end
			end
			tauv_pkg::S_CHECK: begin
				if (stat.pre_bad) begin
					state_n = tauv_pkg::S_ERR;
				end else begin
					op_n = tauv_pkg::OP_TILE;
					state_n = tauv_pkg::S_LAUNCH;
				end
			end
			tauv_pkg::S_LAUNCH: begin
				cmd.div_start = 1'b1;
				state_n = tauv_pkg::S_WAIT;
			end
			tauv_pkg::S_WAIT: begin
				cmd.capture = 1'b1;
				if (stat.div_done) begin
					if (stat.q_bad) begin
						state_n = tauv_pkg::S_ERR;
					end else if (op_q == tauv_pkg::OP_ORG) begin
						if (!axis_q) begin
							axis_n = 1'b1;
							state_n = tauv_pkg::S_CHECK;
						end else begin
							state_n = tauv_pkg::S_INIT;
						end
					end else begin
						op_n = tauv_pkg::next_op(op_q);
						state_n = tauv_pkg::S_LAUNCH;
					end
				end
			end
			tauv_pkg::S_INIT: begin
				cmd.emit_init = 1'b1;
				state_n = tauv_pkg::S_EMIT;
			end
			tauv_pkg::S_EMIT: begin
				cmd.emit_step = 1'b1;
				if (stat.tile_last) begin
					state_n = tauv_pkg::S_IDLE;
				end
			end
			tauv_pkg::S_ERR: begin
				cmd.emit_err = 1'b1;
				state_n = tauv_pkg::S_IDLE;
			end
			default: begin
				state_n = tauv_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != tauv_pkg::S_IDLE);

endmodule

>>> rtl/tile_atlas_uv_grid.sv
// tile_atlas_uv_grid: top level, uv rectangles for the tiles of one atlas region
// joins the sequencer and the datapath; configuration port for the atlas size
// depends on tauv_pkg, tauv_ctrl, tauv_dp
//
// a region is taken when start is high and busy is low; busy drops at the same edge
// that puts the last result of that region on the result ports, so the next region
// can be taken while that result is still showing. results appear one per cycle on
// result, each marked by a one-cycle strobe, and cannot be held off by the receiver.
// both axes go through six divisions each on one shared divider that retires four
// quotient bits a cycle; after that setup a region emits one tile per cycle, up to
// 64 tiles at the default MAX_SUBDIVISIONS; the last result is on the ports in the
// first cycle that busy is low. an error is reported as soon as it is found, so
// error results come sooner. atlas width and height are written through cfg_we,
// cfg_index and cfg_data; write them only while the block is idle, as the block
// itself does not enforce this.
module tile_atlas_uv_grid #(
	parameter int MAX_SUBDIVISIONS = 8,
	parameter int UV_FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  tauv_pkg::item_t item,
	output tauv_pkg::result_t result,
	output logic strobe,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [tauv_pkg::ATLAS_W-1:0] cfg_data
);

	tauv_pkg::dp_cmd_t cmd;
	tauv_pkg::dp_stat_t stat;

	tauv_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.stat(stat)
	);

	tauv_dp #(
		.MAX_SUBDIVISIONS(MAX_SUBDIVISIONS),
		.UV_FRACTION_BITS(UV_FRACTION_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item),
		.cmd(cmd),
		.stat(stat),
		.result(result),
		.strobe(strobe)
	);

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.error |-> result.last)
		else $error("error result without last");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item taken but block not busy");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.last)
		else $error("block went idle without a last result");

	a_mid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && busy |-> !result.last)
		else $error("last result while region still running");

endmodule

>>> dv/tile_atlas_uv_checker.sv
// tile_atlas_uv_checker: watches the region, result and atlas write channels of
// tile_atlas_uv_grid, predicts every uv rectangle and compares in arrival order
// depends on tauv_pkg
module tile_atlas_uv_checker
	import tauv_pkg::*;
#(
	parameter int MAX_SUBDIVISIONS = 8,
	parameter int UV_FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  item_t item,
	input  result_t result,
	input  logic strobe,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [ATLAS_W-1:0] cfg_data,
	output int mismatches,
	output int outstanding,
	output int regions_seen,
	output int rects_seen,
	output int faults_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] UV_ONE = 64'd1 << UV_FRACTION_BITS;

	typedef struct packed {
		logic ok;
		logic [63:0] pitch;
		logic [63:0] size;
		logic [63:0] org;
	} span_t;

	logic [ATLAS_W-1:0] atlas_w;
	logic [ATLAS_W-1:0] atlas_h;
	result_t due_rects[$];

	function automatic logic [OUT_W-1:0] clip_uv(input logic [63:0] v);
		return (v > 64'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
	endfunction

	function automatic span_t single_span(input logic [63:0] a, input logic [63:0] ext,
			input logic [63:0] pos);
		span_t s;
		logic [63:0] d;
		s = '0;
		if (ext != 0 && a >= ext) begin
			d = a / ext;
			s.size = ((d * ext * UV_ONE) / a) / d;
			s.org = s.size * pos;
			s.ok = (s.size != 0);
		end
		return s;
	endfunction

	function automatic span_t grid_span(input logic [63:0] a, input logic [63:0] ext,
			input logic [63:0] n, input logic [63:0] pad, input logic [63:0] pos);
		span_t s;
		logic [63:0] gaps, tile, blk, d;
		s = '0;
		if (n != 0) begin
			gaps = pad * (n - 1);
			if (ext >= gaps) begin
				tile = (ext - gaps) / n;
				blk = tile + pad;
				if (tile != 0 && a >= blk) begin
					d = a / blk;
					s.pitch = ((d * blk * UV_ONE) / a) / d;
					s.size = (s.pitch * tile) / blk;
					s.org = (s.pitch * pos) / blk;
					s.ok = (s.pitch != 0) && (s.size != 0);
				end
			end
		end
		return s;
	endfunction

	task automatic add_rect(input result_t r);
		due_rects.push_back(r);
		outstanding++;
	endtask

	task automatic plan_region(input item_t it);
		span_t sx, sy;
		result_t r, fault;
		logic [63:0] nx, ny, ix, iy, xi, yi;
		fault = '0;
		fault.last = 1'b1;
		fault.error = 1'b1;
		r = '0;
		regions_seen++;
		if (it.kind == KIND_SINGLE) begin
			sx = single_span(64'(atlas_w), 64'(it.region_width), 64'(it.region_min_x));
			sy = single_span(64'(atlas_h), 64'(it.region_height), 64'(it.region_min_y));
			if (sx.ok && sy.ok) begin
				r.corner_u = clip_uv(sx.org);
				r.corner_v = clip_uv(sy.org);
				r.size_u = clip_uv(sx.size);
				r.size_v = clip_uv(sy.size);
				r.last = 1'b1;
				add_rect(r);
			end else begin
				add_rect(fault);
			end
		end else if (it.kind == KIND_BAD) begin
			add_rect(fault);
		end else begin
			nx = 64'(it.tiles_x);
			ny = 64'(it.tiles_y);
			if (nx > MAX_SUBDIVISIONS) nx = MAX_SUBDIVISIONS;
			if (ny > MAX_SUBDIVISIONS) ny = MAX_SUBDIVISIONS;
			sx = grid_span(64'(atlas_w), 64'(it.region_width), nx, 64'(it.pad_x),
				64'(it.region_min_x));
			sy = grid_span(64'(atlas_h), 64'(it.region_height), ny, 64'(it.pad_y),
				64'(it.region_min_y));
			if (!(sx.ok && sy.ok)) begin
				add_rect(fault);
			end else begin
				for (ix = 0; ix < nx; ix++) begin
					xi = (it.kind == KIND_DESC) ? nx - 1 - ix : ix;
					for (iy = 0; iy < ny; iy++) begin
						yi = (it.kind == KIND_DESC) ? ny - 1 - iy : iy;
						r.corner_u = clip_uv(sx.org + xi * sx.pitch);
						r.corner_v = clip_uv(sy.org + yi * sy.pitch);
						r.size_u = clip_uv(sx.size);
						r.size_v = clip_uv(sy.size);
						r.last = (ix == nx - 1) && (iy == ny - 1);
						r.error = 1'b0;
						add_rect(r);
					end
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			atlas_w = ATLAS_RESET;
			atlas_h = ATLAS_RESET;
			due_rects.delete();
			mismatches = 0;
			outstanding = 0;
			regions_seen = 0;
			rects_seen = 0;
			faults_seen = 0;
		end else begin
			if (strobe) begin
				rects_seen++;
				if (result.error) faults_seen++;
				if (due_rects.size() == 0) begin
					$display("%0t: unexpected result 0x%0h with no region pending",
						$time, result);
					mismatches++;
				end else begin
					want = due_rects.pop_front();
					outstanding--;
					check_field("corner_u", want.corner_u, result.corner_u);
					check_field("corner_v", want.corner_v, result.corner_v);
					check_field("size_u", want.size_u, result.size_u);
					check_field("size_v", want.size_v, result.size_v);
					check_field("last", OUT_W'(want.last), OUT_W'(result.last));
					check_field("error", OUT_W'(want.error), OUT_W'(result.error));
				end
			end
			if (start && !busy) plan_region(item);
			if (cfg_we) begin
				if (cfg_index == CFG_ATLAS_WIDTH) atlas_w = cfg_data;
				else atlas_h = cfg_data;
			end
		end
	end

endmodule

>>> dv/tb_top.sv
// tb_top: drives regions and atlas size writes into tile_atlas_uv_grid and gives the verdict
// directed corner regions, then shaped random regions over several atlas sizes
// depends on tauv_pkg, tile_atlas_uv_grid, tile_atlas_uv_checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tauv_pkg::*;

	localparam int MAX_SUBDIVISIONS = 8;
	localparam int UV_FRACTION_BITS = 16;
	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [KIND_W-1:0] KIND_ASC = 2'd1;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	result_t result;
	logic strobe;
	logic cfg_we;
	logic cfg_index;
	logic [ATLAS_W-1:0] cfg_data;

	int mismatches;
	int outstanding;
	int regions_seen;
	int rects_seen;
	int faults_seen;
	int cycles = 0;
	int idle_pct = 0;
	int aw_now = 1024;
	int ah_now = 1024;
	int settings_run = 1;

	tile_atlas_uv_grid #(
		.MAX_SUBDIVISIONS(MAX_SUBDIVISIONS),
		.UV_FRACTION_BITS(UV_FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result(result),
		.strobe(strobe),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tile_atlas_uv_checker #(
		.MAX_SUBDIVISIONS(MAX_SUBDIVISIONS),
		.UV_FRACTION_BITS(UV_FRACTION_BITS)
	) rect_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result(result),
		.strobe(strobe),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.regions_seen(regions_seen),
		.rects_seen(rects_seen),
		.faults_seen(faults_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
			$display("tile_atlas_uv_grid verification failed");
			$finish;
		end
	end

	function automatic item_t region_item(input logic [KIND_W-1:0] kind, input int mx,
			input int my, input int w, input int h, input int tx, input int ty,
			input int px, input int py);
		item_t it;
		it.kind = kind;
		it.region_min_x = POS_W'(mx);
		it.region_min_y = POS_W'(my);
		it.region_width = EXT_W'(w);
		it.region_height = EXT_W'(h);
		it.tiles_x = CNT_W'(tx);
		it.tiles_y = CNT_W'(ty);
		it.pad_x = PAD_W'(px);
		it.pad_y = PAD_W'(py);
		return it;
	endfunction

	function automatic item_t noise_item();
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		return raw[$bits(item_t)-1:0];
	endfunction

	function automatic int pick_corner();
		return ($urandom_range(3) == 0) ? int'($urandom_range(0, 16383))
			: int'($urandom_range(0, 64));
	endfunction

	// extent that leaves whole tiles which still fit the atlas when it is wider than the pad
	function automatic int pick_extent(input int a, input int n, input int pad);
		int hi, tmax, tile, ext;
		hi = (32767 - pad * (n - 1)) / n;
		tmax = a - pad;
		if (tmax > hi) tmax = hi;
		if (tmax < 1) tmax = 1;
		if (tmax > 64 && $urandom_range(1) == 0) tmax = 64;
		tile = int'($urandom_range(1, tmax));
		ext = tile * n + pad * (n - 1) + int'($urandom_range(0, n - 1));
		return (ext > 32767) ? 32767 : ext;
	endfunction

	function automatic item_t random_region();
		item_t it;
		int roll, nx, ny, px, py, amax;
		roll = int'($urandom_range(99));
		it = noise_item();
		if (roll >= 15 && roll < 35) begin
			amax = (aw_now < 1) ? 1 : (aw_now > 32767 ? 32767 : aw_now);
			it.kind = KIND_SINGLE;
			it.region_width = EXT_W'($urandom_range(1, amax));
			amax = (ah_now < 1) ? 1 : (ah_now > 32767 ? 32767 : ah_now);
			it.region_height = EXT_W'($urandom_range(1, amax));
			it.region_min_x = POS_W'(pick_corner());
			it.region_min_y = POS_W'(pick_corner());
		end else if (roll >= 35) begin
			nx = ($urandom_range(9) == 0) ? int'($urandom_range(9, 15)) : int'($urandom_range(1, 8));
			ny = ($urandom_range(9) == 0) ? int'($urandom_range(9, 15)) : int'($urandom_range(1, 8));
			px = ($urandom_range(3) == 0) ? int'($urandom_range(0, 255)) : int'($urandom_range(0, 8));
			py = ($urandom_range(3) == 0) ? int'($urandom_range(0, 255)) : int'($urandom_range(0, 8));
			it = region_item(($urandom_range(1) == 0) ? KIND_ASC : KIND_DESC,
				pick_corner(), pick_corner(),
				pick_extent(aw_now, (nx > 8) ? 8 : nx, px),
				pick_extent(ah_now, (ny > 8) ? 8 : ny, py),
				nx, ny, px, py);
		end
		return it;
	endfunction

	function automatic int idle_gap(input int pct);
		int g;
		g = 0;
		if (pct > 0) begin
			if ($urandom_range(7) == 0) begin
				g = int'($urandom_range(1, 150));
			end else begin
				while (int'($urandom_range(99)) < pct && g < 40) g++;
			end
		end
		return g;
	endfunction

	task automatic send(input item_t it);
		int gap;
		gap = idle_gap(idle_pct);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			item <= noise_item();
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
	endtask

	task automatic run_random(input int count, input int pct);
		idle_pct = pct;
		repeat (count) send(random_region());
	endtask

	task automatic quiesce(input int settle);
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic set_atlas(input int w, input int h);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ATLAS_WIDTH;
		cfg_data <= ATLAS_W'(w);
		@(negedge clk);
		cfg_index <= CFG_ATLAS_HEIGHT;
		cfg_data <= ATLAS_W'(h);
		@(negedge clk);
		cfg_we <= 1'b0;
		aw_now = w;
		ah_now = h;
		settings_run++;
	endtask

	initial begin
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_ATLAS_WIDTH;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset atlas size, directed corners first
		send(region_item(KIND_SINGLE, 0, 0, 1024, 1024, 0, 0, 0, 0));
		send(region_item(KIND_SINGLE, 16383, 16383, 1, 1, 15, 15, 255, 255));
		send(region_item(KIND_SINGLE, 100, 200, 0, 50, 2, 2, 1, 1));
		send(region_item(KIND_SINGLE, 0, 0, 300, 32767, 0, 0, 0, 0));
		send(region_item(KIND_SINGLE, 37, 5, 1000, 3, 8, 1, 17, 0));
		send(region_item(KIND_SINGLE, 0, 16383, 1024, 1, 0, 0, 0, 0));
		send(region_item(KIND_ASC, 0, 0, 1024, 1024, 4, 4, 0, 0));
		send(region_item(KIND_DESC, 0, 0, 1024, 1024, 4, 2, 8, 8));
		send(region_item(KIND_ASC, 16383, 16383, 1024, 1024, 8, 8, 0, 0));
		send(region_item(KIND_DESC, 512, 256, 512, 512, 15, 9, 1, 2));
		send(region_item(KIND_ASC, 0, 0, 512, 512, 0, 4, 0, 0));
		send(region_item(KIND_DESC, 0, 0, 512, 512, 3, 0, 0, 0));
		send(region_item(KIND_BAD, 0, 0, 512, 512, 2, 2, 0, 0));
		send(region_item(KIND_ASC, 0, 0, 100, 100, 2, 2, 255, 0));
		send(region_item(KIND_ASC, 0, 0, 3, 64, 4, 1, 0, 0));
		send(region_item(KIND_ASC, 0, 0, 32767, 64, 1, 1, 0, 0));
		send(region_item(KIND_DESC, 10, 20, 1000, 1000, 3, 3, 255, 255));
		send(region_item(KIND_ASC, 0, 0, 16384, 16384, 2, 2, 0, 0));
		send(region_item(KIND_DESC, 1, 1, 7, 7, 7, 7, 0, 0));
		run_random(60, 0);

		quiesce(8);
		set_atlas(16384, 16384);
		send(region_item(KIND_SINGLE, 0, 0, 16384, 16384, 0, 0, 0, 0));
		send(region_item(KIND_ASC, 0, 0, 16384, 16384, 8, 8, 0, 0));
		run_random(55, 56);

		quiesce(8);
		set_atlas(1, 16384);
		run_random(20, 19);

		quiesce(8);
		set_atlas(32767, 0);
		run_random(15, 0);

		quiesce(8);
		set_atlas(600, 333);
		run_random(50, 56);

		quiesce(DRAIN_CYCLES);
		$display("covered %0d regions over %0d atlas sizes", regions_seen, settings_run);
		$display("checked %0d rectangles, %0d of them error results, %0d mismatches",
			rects_seen, faults_seen, mismatches);
		if (mismatches == 0) begin
			$display("tile_atlas_uv_grid verification clean");
		end else begin
			$display("tile_atlas_uv_grid verification failed");
		end
		$finish;
	end

endmodule
